/* rtl/core/vct_pkg.sv */
// Shared types, constants and helpers for the vertex camera transform block.
package vct_pkg;

  // Fixed-point format and near plane distance
  localparam int FracBits  = 16;
  localparam int NearDist  = 65536;

  // Datapath widths
  localparam int CfgIdxW   = 4;
  localparam int FocalW    = 12;
  localparam int NumW      = 44;               // |rel * focal| < 2^43
  localparam int DvdW      = NumW + FracBits;  // scaled dividend
  localparam int DivisorW  = 33;               // |dif_y| <= 2^32
  localparam int QsW       = DvdW + 1;         // signed quotient
  localparam int WideW     = 72;               // headroom for saturation
  localparam int RotW      = 52;
  localparam int RotShift  = 14;
  localparam int RoundHalf = 8192;
  localparam int TLimExp   = 30;
  localparam int CenterW   = 1 + 12 + FracBits;
  localparam int QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCamPosX   = 4'd0,
    CfgCamPosY   = 4'd1,
    CfgCamPosZ   = 4'd2,
    CfgCosAngle  = 4'd3,
    CfgSinAngle  = 4'd4,
    CfgFocal     = 4'd5,
    CfgHalfWidth = 4'd6,
    CfgHalfHeight = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] cam_pos_x;
    logic signed [31:0] cam_pos_y;
    logic signed [31:0] cam_pos_z;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic [FocalW-1:0]  focal_length;
    logic [11:0]        half_width;
    logic [11:0]        half_height;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] rel_z;
    logic               in_view;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               screen_valid;
  } out_item_t;

  typedef enum logic [1:0] {
    JobNone    = 2'd0,
    JobProject = 2'd1,
    JobNear    = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] rel_z;
    logic               in_view;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] prev_z;
    logic signed [32:0] dif_x;
    logic signed [32:0] dif_y;
    logic signed [32:0] dif_z;
  } job_t;

  typedef struct packed {
    logic                start;
    logic [DivisorW-1:0] divisor;
    logic [DvdW-1:0]     dvd0;
    logic [DvdW-1:0]     dvd1;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quo0;
    logic [DvdW-1:0] quo1;
  } div_rsp_t;

  typedef enum logic [2:0] {
    FrIdle, FrTrans, FrMul, FrRot, FrPush
  } fr_state_t;

  typedef enum logic [3:0] {
    BkIdle, BkMul, BkStart, BkDiv, BkMulT, BkAdd, BkMulF, BkFin, BkOut
  } bk_state_t;

  // Clamp a wide two's complement value to 32 bits
  function automatic logic [31:0] sat32(input logic [WideW-1:0] v);
    logic [WideW-32:0] top;
    top = v[WideW-1:31];
    if (top == '0 || top == '1) return v[31:0];
    return v[WideW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // Magnitude of a 32-bit signed value
  function automatic logic [32:0] abs33(input logic signed [31:0] v);
    return v[31] ? 33'(-33'(v)) : 33'(v);
  endfunction

endpackage

/* rtl/core/vct_front.sv */
// Front end: accepts a vertex, translates and rotates it, classifies the projection job.
module vct_front (
  input  logic             clk,
  input  logic             rst,
  input  vct_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  vct_pkg::in_item_t in_data,
  output logic             job_valid,
  input  logic             job_ready,
  output vct_pkg::job_t    job
);

  vct_pkg::fr_state_t state, state_next;
  vct_pkg::in_item_t  item;
  logic signed [32:0] dx, dy, dz;
  logic signed [48:0] p_xc, p_ys, p_yc, p_xs;
  logic signed [31:0] rx, ry, rz;
  logic signed [31:0] prev_x, prev_y, prev_z;
  logic signed [vct_pkg::RotW-1:0] sum_x, sum_y, rot_x, rot_y;

  // Rotation sums with round half up and floor shift
  always_comb begin
    sum_x = vct_pkg::RotW'(p_xc) + vct_pkg::RotW'(p_ys) + vct_pkg::RotW'(vct_pkg::RoundHalf);
    sum_y = vct_pkg::RotW'(p_yc) - vct_pkg::RotW'(p_xs) + vct_pkg::RotW'(vct_pkg::RoundHalf);
    rot_x = sum_x >>> vct_pkg::RotShift;
    rot_y = sum_y >>> vct_pkg::RotShift;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vct_pkg::FrIdle;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshakes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    job_valid  = 1'b0;
    case (state)
      vct_pkg::FrIdle: begin
        in_ready = 1'b1;
        if (in_valid) state_next = vct_pkg::FrTrans;
      end
      vct_pkg::FrTrans: state_next = vct_pkg::FrMul;
      vct_pkg::FrMul:   state_next = vct_pkg::FrRot;
      vct_pkg::FrRot:   state_next = vct_pkg::FrPush;
      vct_pkg::FrPush: begin
        job_valid = 1'b1;
        if (job_ready) state_next = vct_pkg::FrIdle;
      end
      default: state_next = vct_pkg::FrIdle;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      prev_z <= '0;
    end else begin
      case (state)
        vct_pkg::FrIdle: begin
          if (in_valid) item <= in_data;
        end
        vct_pkg::FrTrans: begin
          dx <= 33'(item.world_x) - 33'(cfg.cam_pos_x);
          dy <= 33'(item.world_y) - 33'(cfg.cam_pos_y);
          dz <= 33'(item.world_z) - 33'(cfg.cam_pos_z);
        end
        vct_pkg::FrMul: begin
          p_xc <= dx * cfg.cos_angle;
          p_ys <= dy * cfg.sin_angle;
          p_yc <= dy * cfg.cos_angle;
          p_xs <= dx * cfg.sin_angle;
        end
        vct_pkg::FrRot: begin
          rx <= vct_pkg::sat32(vct_pkg::WideW'(rot_x));
          ry <= vct_pkg::sat32(vct_pkg::WideW'(rot_y));
          rz <= vct_pkg::sat32(vct_pkg::WideW'(dz));
        end
        vct_pkg::FrPush: begin
          if (job_ready) begin
            prev_x <= rx;
            prev_y <= ry;
            prev_z <= rz;
          end
        end
        default: ;
      endcase
    end
  end

  // Job record
  always_comb begin
    job.rel_x   = rx;
    job.rel_y   = ry;
    job.rel_z   = rz;
    job.in_view = !ry[31] && ({1'b0, ry} > vct_pkg::abs33(rx))
                  && ({1'b0, ry} > vct_pkg::abs33(rz));
    job.prev_x  = prev_x;
    job.prev_y  = prev_y;
    job.prev_z  = prev_z;
    job.dif_x   = 33'(rx) - 33'(prev_x);
    job.dif_y   = 33'(ry) - 33'(prev_y);
    job.dif_z   = 33'(rz) - 33'(prev_z);
    if (!item.op) begin
      job.kind = (!ry[31] && ry != 32'sd0) ? vct_pkg::JobProject : vct_pkg::JobNone;
    end else begin
      job.kind = (ry != prev_y) ? vct_pkg::JobNear : vct_pkg::JobNone;
    end
  end

endmodule

/* rtl/core/vct_queue.sv */
// Two-entry job queue between the front and back ends.
module vct_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  vct_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop,
  output vct_pkg::job_t pop_job
);

  vct_pkg::job_t entries [vct_pkg::QueueDepth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'(vct_pkg::QueueDepth));
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

endmodule

/* rtl/core/vct_div.sv */
// Two-lane unsigned restoring divider with a shared divisor, two quotient bits per cycle.
module vct_div (
  input  logic              clk,
  input  logic              rst,
  input  vct_pkg::div_req_t req,
  output vct_pkg::div_rsp_t rsp
);

  localparam int Steps = vct_pkg::DvdW / 2;
  localparam int CntW  = $clog2(Steps);
  localparam int PairW = vct_pkg::DivisorW + vct_pkg::DvdW;

  logic                         busy, done;
  logic [CntW-1:0]              cnt;
  logic [vct_pkg::DivisorW-1:0] dvsr, rem0, rem1;
  logic [vct_pkg::DvdW-1:0]     dvd0, dvd1;
  logic [PairW-1:0]             s0a, s0b, s1a, s1b;

  // One restoring step: shift in the next dividend bit, subtract when it fits
  function automatic logic [PairW-1:0] div_step(
    input logic [vct_pkg::DivisorW-1:0] rem,
    input logic [vct_pkg::DvdW-1:0]     dvd,
    input logic [vct_pkg::DivisorW-1:0] d
  );
    logic [vct_pkg::DivisorW:0] trial;
    logic                       fits;
    trial = {rem, dvd[vct_pkg::DvdW-1]};
    fits  = (trial >= {1'b0, d});
    if (fits) trial = trial - {1'b0, d};
    return {trial[vct_pkg::DivisorW-1:0], dvd[vct_pkg::DvdW-2:0], fits};
  endfunction

  always_comb begin
    s0a = div_step(rem0, dvd0, dvsr);
    s0b = div_step(s0a[PairW-1:vct_pkg::DvdW], s0a[vct_pkg::DvdW-1:0], dvsr);
    s1a = div_step(rem1, dvd1, dvsr);
    s1b = div_step(s1a[PairW-1:vct_pkg::DvdW], s1a[vct_pkg::DvdW-1:0], dvsr);
  end

  // Iteration control and lane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvsr <= req.divisor;
        rem0 <= '0;
        rem1 <= '0;
        dvd0 <= req.dvd0;
        dvd1 <= req.dvd1;
      end else if (busy) begin
        {rem0, dvd0} <= s0b;
        {rem1, dvd1} <= s1b;
        cnt <= cnt + CntW'(1);
        if (cnt == CntW'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo0 = dvd0;
  assign rsp.quo1 = dvd1;

endmodule

/* rtl/core/vct_back.sv */
// Back end: runs the perspective or near-plane projection when the job needs one and holds the result beat.
module vct_back (
  input  logic               clk,
  input  logic               rst,
  input  vct_pkg::cfg_t      cfg,
  input  logic               job_valid,
  output logic               job_pop,
  input  vct_pkg::job_t      job,
  output vct_pkg::div_req_t  div_req,
  input  vct_pkg::div_rsp_t  div_rsp,
  output logic               out_valid,
  input  logic               out_ready,
  output vct_pkg::out_item_t out_data
);

  localparam logic signed [vct_pkg::QsW-1:0] TLim =
    vct_pkg::QsW'(64'sd1 <<< vct_pkg::TLimExp);

  vct_pkg::bk_state_t state, state_next;
  vct_pkg::job_t      j;
  logic signed [vct_pkg::NumW-1:0] num_x, num_z, fx, fz;
  logic signed [31:0] t, tx, tz, sx, sy;
  logic signed [65:0] px, pz;
  logic               neg0, neg1, scr_valid;
  logic signed [vct_pkg::CenterW-1:0] cx, cy;
  logic signed [vct_pkg::QsW-1:0]     q0s, q1s;
  logic [vct_pkg::NumW-1:0]           mag_x, mag_z, shx, shz;
  logic signed [vct_pkg::FocalW:0]    focal_s;
  logic                               out_free;
  vct_pkg::out_item_t                 res;

  assign cx       = {1'b0, cfg.half_width, vct_pkg::FracBits'(0)};
  assign cy       = {1'b0, cfg.half_height, vct_pkg::FracBits'(0)};
  assign focal_s  = {1'b0, cfg.focal_length};
  assign out_free = !out_valid || out_ready;

  // Signed quotients and near-plane magnitudes
  always_comb begin
    q0s   = neg0 ? -vct_pkg::QsW'(div_rsp.quo0) : vct_pkg::QsW'(div_rsp.quo0);
    q1s   = neg1 ? -vct_pkg::QsW'(div_rsp.quo1) : vct_pkg::QsW'(div_rsp.quo1);
    mag_x = fx[vct_pkg::NumW-1] ? vct_pkg::NumW'(-fx) : vct_pkg::NumW'(fx);
    mag_z = fz[vct_pkg::NumW-1] ? vct_pkg::NumW'(-fz) : vct_pkg::NumW'(fz);
    shx   = mag_x / vct_pkg::NearDist;
    shz   = mag_z / vct_pkg::NearDist;
  end

  // Divider request
  always_comb begin
    div_req.start   = (state == vct_pkg::BkStart);
    div_req.divisor = (j.kind == vct_pkg::JobProject) ? 33'(j.rel_y)
                    : (j.dif_y[32] ? 33'(-j.dif_y) : 33'(j.dif_y));
    div_req.dvd0 = {(num_x[vct_pkg::NumW-1] ? vct_pkg::NumW'(-num_x)
                                            : vct_pkg::NumW'(num_x)),
                    vct_pkg::FracBits'(0)};
    div_req.dvd1 = {(num_z[vct_pkg::NumW-1] ? vct_pkg::NumW'(-num_z)
                                            : vct_pkg::NumW'(num_z)),
                    vct_pkg::FracBits'(0)};
  end

  // Result beat
  always_comb begin
    res.rel_x        = j.rel_x;
    res.rel_y        = j.rel_y;
    res.rel_z        = j.rel_z;
    res.in_view      = j.in_view;
    res.screen_x     = sx;
    res.screen_y     = sy;
    res.screen_valid = scr_valid;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vct_pkg::BkIdle;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    case (state)
      vct_pkg::BkIdle: begin
        if (job_valid) begin
          job_pop = 1'b1;
          case (job.kind)
            vct_pkg::JobProject: state_next = vct_pkg::BkMul;
            vct_pkg::JobNear:    state_next = vct_pkg::BkStart;
            default:             state_next = vct_pkg::BkOut;
          endcase
        end
      end
      vct_pkg::BkMul:   state_next = vct_pkg::BkStart;
      vct_pkg::BkStart: state_next = vct_pkg::BkDiv;
      vct_pkg::BkDiv: begin
        if (div_rsp.done) begin
          state_next = (j.kind == vct_pkg::JobProject) ? vct_pkg::BkOut : vct_pkg::BkMulT;
        end
      end
      vct_pkg::BkMulT: state_next = vct_pkg::BkAdd;
      vct_pkg::BkAdd:  state_next = vct_pkg::BkMulF;
      vct_pkg::BkMulF: state_next = vct_pkg::BkFin;
      vct_pkg::BkFin:  state_next = vct_pkg::BkOut;
      vct_pkg::BkOut: begin
        if (out_free) state_next = vct_pkg::BkIdle;
      end
      default: state_next = vct_pkg::BkIdle;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      vct_pkg::BkIdle: begin
        if (job_valid) begin
          j         <= job;
          sx        <= '0;
          sy        <= '0;
          scr_valid <= 1'b0;
          num_x     <= vct_pkg::NumW'(vct_pkg::NearDist) - vct_pkg::NumW'(job.prev_y);
          num_z     <= '0;
        end
      end
      vct_pkg::BkMul: begin
        num_x <= j.rel_x * focal_s;
        num_z <= j.rel_z * focal_s;
      end
      vct_pkg::BkStart: begin
        neg0 <= num_x[vct_pkg::NumW-1] ^ ((j.kind == vct_pkg::JobNear) && j.dif_y[32]);
        neg1 <= num_z[vct_pkg::NumW-1];
      end
      vct_pkg::BkDiv: begin
        if (div_rsp.done) begin
          if (j.kind == vct_pkg::JobProject) begin
            sx        <= vct_pkg::sat32(vct_pkg::WideW'(cx) + vct_pkg::WideW'(q0s));
            sy        <= vct_pkg::sat32(vct_pkg::WideW'(cy) - vct_pkg::WideW'(q1s));
            scr_valid <= 1'b1;
          end else if (q0s > TLim) begin
            t <= 32'(TLim);
          end else if (q0s < -TLim) begin
            t <= 32'(-TLim);
          end else begin
            t <= 32'(q0s);
          end
        end
      end
      vct_pkg::BkMulT: begin
        px <= t * j.dif_x;
        pz <= t * j.dif_z;
      end
      vct_pkg::BkAdd: begin
        tx <= vct_pkg::sat32(vct_pkg::WideW'(j.prev_x)
                             + vct_pkg::WideW'(px >>> vct_pkg::FracBits));
        tz <= vct_pkg::sat32(vct_pkg::WideW'(j.prev_z)
                             + vct_pkg::WideW'(pz >>> vct_pkg::FracBits));
      end
      vct_pkg::BkMulF: begin
        fx <= tx * focal_s;
        fz <= tz * focal_s;
      end
      vct_pkg::BkFin: begin
        // Truncating divide by the near distance on the magnitude
        sx <= vct_pkg::sat32(vct_pkg::WideW'(cx) + (fx[vct_pkg::NumW-1]
                ? -vct_pkg::WideW'(shx) : vct_pkg::WideW'(shx)));
        sy <= vct_pkg::sat32(vct_pkg::WideW'(cy) - (fz[vct_pkg::NumW-1]
                ? -vct_pkg::WideW'(shz) : vct_pkg::WideW'(shz)));
        scr_valid <= 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == vct_pkg::BkOut && out_free) begin
      out_valid <= 1'b1;
      out_data  <= res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/vertex_camera_transform_project_unit.sv */
// Top level: configuration registers, front end, job queue, divider and back end.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one beat is one world vertex with
//    an op bit; op 0 projects the vertex, op 1 projects the near-plane crossing of
//    the edge from the previous vertex.
//  - Output channel (out_valid/out_ready/out_data): one beat per input beat, in order.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//    only while the block is idle. Indexes past the register list are dropped.
//  - Projections run through the divider, which retires two quotient bits per
//    cycle over a 60-bit dividend. The front end takes a new vertex only once
//    it has pushed its last job into the queue; the queue holds two jobs, so
//    the front end can run ahead of the back end.
//  - Reset clears the camera registers to their defaults and the previous vertex
//    to zero. A stalled output keeps its beat; the back end and then the queue
//    and front end fill up behind it.
module vertex_camera_transform_project_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  vct_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output vct_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [vct_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);

  vct_pkg::cfg_t     cfg;
  vct_pkg::job_t     push_job, pop_job;
  logic              push_valid, push_ready, pop_valid, pop;
  vct_pkg::div_req_t div_req;
  vct_pkg::div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_pos_x    <= '0;
      cfg.cam_pos_y    <= '0;
      cfg.cam_pos_z    <= '0;
      cfg.cos_angle    <= 16'sd16384;
      cfg.sin_angle    <= '0;
      cfg.focal_length <= 12'd256;
      cfg.half_width   <= 12'd320;
      cfg.half_height  <= 12'd240;
    end else if (cfg_valid) begin
      case (cfg_index)
        vct_pkg::CfgCamPosX:    cfg.cam_pos_x    <= cfg_data;
        vct_pkg::CfgCamPosY:    cfg.cam_pos_y    <= cfg_data;
        vct_pkg::CfgCamPosZ:    cfg.cam_pos_z    <= cfg_data;
        vct_pkg::CfgCosAngle:   cfg.cos_angle    <= cfg_data[15:0];
        vct_pkg::CfgSinAngle:   cfg.sin_angle    <= cfg_data[15:0];
        vct_pkg::CfgFocal:      cfg.focal_length <= cfg_data[11:0];
        vct_pkg::CfgHalfWidth:  cfg.half_width   <= cfg_data[11:0];
        vct_pkg::CfgHalfHeight: cfg.half_height  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  vct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  vct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job)
  );

  vct_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  vct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (pop_valid),
    .job_pop   (pop),
    .job       (pop_job),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/vct_checker.sv */
// Port-level checks for the vertex camera transform block, bound to the top level.
module vct_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input vct_pkg::out_item_t out_data
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped or changed while stalled");

  // No projection means the screen fields read zero
  a_no_proj_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.screen_valid |->
      out_data.screen_x == 32'sd0 && out_data.screen_y == 32'sd0)
    else $error("screen fields nonzero without a projection");

  // Inside the view cone implies positive depth
  a_view_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.in_view |->
      !out_data.rel_y[31] && out_data.rel_y != 32'sd0)
    else $error("in_view set with non-positive depth");

  // Inside the view cone the depth exceeds the lateral offset
  a_view_cone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.in_view |->
      vct_pkg::abs33(out_data.rel_x) < {1'b0, out_data.rel_y})
    else $error("in_view set outside the view cone");

endmodule

bind vertex_camera_transform_project_unit vct_checker u_vct_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* verif/vct_scoreboard.sv */
// Checker for the vertex camera transform block: watches channels, predicts and compares.
module vct_scoreboard (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  vct_pkg::in_item_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  vct_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [vct_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  output int                          fail_count,
  output int                          pending_count
);

  // Shadow copy of the camera registers and previous vertex
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic signed [15:0] cos_q, sin_q;
  logic [11:0]        focal, half_w, half_h;
  logic signed [63:0] last_x, last_y, last_z;
  vct_pkg::out_item_t expected_beats[$];

  assign pending_count = expected_beats.size();

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // trunc(num * 2^sh / den), magnitude capped at 2^60, zero for den 0
  function automatic logic signed [63:0] scaled_quotient(input logic signed [63:0] num,
                                                         input logic signed [63:0] den,
                                                         input int sh);
    logic [63:0] n, d, qi, r, m;
    n = magnitude(num);
    d = magnitude(den);
    if (d == 0) return 0;
    qi = n / d;
    r = n % d;
    if (qi >= (64'd1 << 36)) m = 64'd1 << 60;
    else m = (qi << sh) + ((r << sh) / d);
    if ((num < 0) != (den < 0)) return -$signed(m);
    return $signed(m);
  endfunction

  function automatic vct_pkg::out_item_t project_vertex(input vct_pkg::in_item_t v);
    logic signed [63:0] dx, dy, dz, rx, ry, rz, sx, sy, cx, cy, fl;
    logic signed [63:0] difx, dify, difz, t, tx, tz;
    vct_pkg::out_item_t r;
    dx = 64'(v.world_x) - 64'(cam_x);
    dy = 64'(v.world_y) - 64'(cam_y);
    dz = 64'(v.world_z) - 64'(cam_z);
    rx = clamp32((dx * cos_q + dy * sin_q + 8192) >>> vct_pkg::RotShift);
    ry = clamp32((dy * cos_q - dx * sin_q + 8192) >>> vct_pkg::RotShift);
    rz = clamp32(dz);
    fl = 64'(focal);
    cx = 64'(half_w) << vct_pkg::FracBits;
    cy = 64'(half_h) << vct_pkg::FracBits;
    sx = 0;
    sy = 0;
    r = '0;
    if (!v.op) begin
      if (ry > 0) begin
        sx = clamp32(cx + scaled_quotient(rx * fl, ry, vct_pkg::FracBits));
        sy = clamp32(cy - scaled_quotient(rz * fl, ry, vct_pkg::FracBits));
        r.screen_valid = 1'b1;
      end
    end else begin
      difx = rx - last_x;
      dify = ry - last_y;
      difz = rz - last_z;
      if (dify != 0) begin
        t = scaled_quotient(vct_pkg::NearDist - last_y, dify, vct_pkg::FracBits);
        if (t > (64'sd1 <<< vct_pkg::TLimExp)) t = 64'sd1 <<< vct_pkg::TLimExp;
        if (t < -(64'sd1 <<< vct_pkg::TLimExp)) t = -(64'sd1 <<< vct_pkg::TLimExp);
        tx = clamp32(last_x + ((t * difx) >>> vct_pkg::FracBits));
        tz = clamp32(last_z + ((t * difz) >>> vct_pkg::FracBits));
        sx = clamp32(cx + scaled_quotient(tx * fl, vct_pkg::NearDist, 0));
        sy = clamp32(cy - scaled_quotient(tz * fl, vct_pkg::NearDist, 0));
        r.screen_valid = 1'b1;
      end
    end
    last_x = rx;
    last_y = ry;
    last_z = rz;
    r.rel_x = rx[31:0];
    r.rel_y = ry[31:0];
    r.rel_z = rz[31:0];
    r.in_view = (ry > $signed(magnitude(rx))) && (ry > $signed(magnitude(rz)));
    r.screen_x = sx[31:0];
    r.screen_y = sy[31:0];
    return r;
  endfunction

  // Register writes, input beats and output beats
  always @(posedge clk) begin
    vct_pkg::out_item_t want;
    if (rst) begin
      cam_x <= 0; cam_y <= 0; cam_z <= 0;
      cos_q <= 16'sd16384; sin_q <= 0;
      focal <= 12'd256; half_w <= 12'd320; half_h <= 12'd240;
      last_x = 0; last_y = 0; last_z = 0;
      expected_beats.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (vct_pkg::cfg_idx_t'(cfg_index))
          vct_pkg::CfgCamPosX:    cam_x <= cfg_data;
          vct_pkg::CfgCamPosY:    cam_y <= cfg_data;
          vct_pkg::CfgCamPosZ:    cam_z <= cfg_data;
          vct_pkg::CfgCosAngle:   cos_q <= cfg_data[15:0];
          vct_pkg::CfgSinAngle:   sin_q <= cfg_data[15:0];
          vct_pkg::CfgFocal:      focal <= cfg_data[11:0];
          vct_pkg::CfgHalfWidth:  half_w <= cfg_data[11:0];
          vct_pkg::CfgHalfHeight: half_h <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_beats.push_back(project_vertex(in_data));
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("output beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_beats.pop_front();
          if (want != out_data) begin
            fail_count <= fail_count + 1;
            if (want.rel_x != out_data.rel_x)
              $error("rel_x exp %0d got %0d", want.rel_x, out_data.rel_x);
            if (want.rel_y != out_data.rel_y)
              $error("rel_y exp %0d got %0d", want.rel_y, out_data.rel_y);
            if (want.rel_z != out_data.rel_z)
              $error("rel_z exp %0d got %0d", want.rel_z, out_data.rel_z);
            if (want.in_view != out_data.in_view)
              $error("in_view exp %0d got %0d", want.in_view, out_data.in_view);
            if (want.screen_x != out_data.screen_x)
              $error("screen_x exp %0d got %0d", want.screen_x, out_data.screen_x);
            if (want.screen_y != out_data.screen_y)
              $error("screen_y exp %0d got %0d", want.screen_y, out_data.screen_y);
            if (want.screen_valid != out_data.screen_valid)
              $error("screen_valid exp %0d got %0d", want.screen_valid,
                     out_data.screen_valid);
          end
        end
      end
    end
  end

endmodule

/* verif/vertex_camera_transform_project_unit_tb.sv */
// Testbench top: stimulus, idling, register phases and the verdict.
module vertex_camera_transform_project_unit_tb;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  vct_pkg::in_item_t           in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  vct_pkg::out_item_t          out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [vct_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]                 cfg_data = '0;
  int                          fail_count, pending_count;
  int                          send_gap_pct = 0, recv_stall_pct = 0;

  always #1 clk = ~clk;

  vertex_camera_transform_project_unit dut (.*);

  vct_scoreboard checker_i (.*);

  // Receiver stalls at random
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // One register write beat, then the channel goes idle before the task returns
  task automatic write_reg(input vct_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays up after the beat; the next beat or drain() decides what follows
  task automatic send_vertex(input logic op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, x, y, z};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Coordinate mostly near the camera, sometimes full range
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 22) - (1 << 21);
      default: return $urandom_range(0, 1 << 26) - (1 << 25);
    endcase
  endfunction

  function automatic logic [31:0] rand_trig();
    case ($urandom_range(3))
      0: return $urandom_range(0, 1) ? 32'h4000 : 32'hffff_c000;
      1: return $urandom & 32'hffff;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  task automatic random_settings();
    write_reg(vct_pkg::CfgCamPosX, $urandom_range(0, 1 << 24) - (1 << 23));
    write_reg(vct_pkg::CfgCamPosY, $urandom_range(0, 1 << 24) - (1 << 23));
    write_reg(vct_pkg::CfgCamPosZ, $urandom_range(0, 1 << 24) - (1 << 23));
    write_reg(vct_pkg::CfgCosAngle, rand_trig());
    write_reg(vct_pkg::CfgSinAngle, rand_trig());
    write_reg(vct_pkg::CfgFocal, $urandom_range(0, 4095));
    write_reg(vct_pkg::CfgHalfWidth, $urandom_range(0, 4095));
    write_reg(vct_pkg::CfgHalfHeight, $urandom_range(0, 4095));
  endtask

  // Random vertices, op 1 more often than op 0, depth mostly in a narrow band so edges often cross the near plane
  task automatic random_block(input int count);
    logic [31:0] y;
    repeat (count) begin
      y = ($urandom_range(3) == 0) ? rand_coord()
          : 32'($urandom_range(0, 1 << 20)) - 32'(1 << 18);
      send_vertex($urandom_range(0, 2) != 0, rand_coord(), y, rand_coord());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, field extremes, both ops, special cases
    send_gap_pct = 10;
    recv_stall_pct = 77;
    send_vertex(1'b0, 32'h0001_0000, 32'h0004_0000, 32'h0000_8000);
    send_vertex(1'b0, 32'h0, 32'h0, 32'h0);                  // not in front
    send_vertex(1'b0, 32'h0, 32'hfffe_0000, 32'h0);          // behind camera
    send_vertex(1'b1, 32'h0001_0000, 32'h0003_0000, 32'h0);  // crossing
    send_vertex(1'b1, 32'h0002_0000, 32'h0003_0000, 32'h0);  // parallel edge
    send_vertex(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(1'b0, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff);
    send_vertex(1'b1, 32'hffff_ffff, 32'h7fff_ffff, 32'h0);
    send_vertex(1'b0, 32'h0, 32'h0000_0001, 32'h8000_0000);
    send_vertex(1'b1, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    drain();

    // Register extremes: saturating translation, cos -1.0 with sin 1.0, focal zero
    write_reg(vct_pkg::CfgCamPosX, 32'h8000_0000);
    write_reg(vct_pkg::CfgCamPosY, 32'h7fff_ffff);
    write_reg(vct_pkg::CfgCamPosZ, 32'h8000_0000);
    write_reg(vct_pkg::CfgCosAngle, 32'hffff_c000);
    write_reg(vct_pkg::CfgSinAngle, 32'h0000_4000);
    write_reg(vct_pkg::CfgFocal, 32'h0);
    write_reg(vct_pkg::CfgHalfWidth, 32'hfff);
    write_reg(vct_pkg::CfgHalfHeight, 32'h0);
    send_vertex(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_vertex(1'b1, 32'h0, 32'h0, 32'h0);
    send_vertex(1'b0, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    drain();
    write_reg(vct_pkg::CfgFocal, 32'hfff);
    write_reg(vct_pkg::CfgSinAngle, 32'h7fff);                        // out-of-range trig
    write_reg(vct_pkg::cfg_idx_t'(4'd9), 32'h1234);                    // dropped index
    send_vertex(1'b0, 32'h8000_0000, 32'h0, 32'h8000_0000);
    send_vertex(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    send_vertex(1'b0, 32'h0, 32'h7fff_ffff, 32'h0);
    drain();

    // Random phases with fresh settings between them
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin send_gap_pct = 77; recv_stall_pct = 10; end
      if (phase == 6) begin send_gap_pct = 0; recv_stall_pct = 0; end
      random_settings();
      random_block(70);
      drain();
    end

    if (fail_count == 0 && pending_count == 0)
      $display("vertex_camera_transform_project_unit verification clean");
    else
      $display("vertex_camera_transform_project_unit verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("vertex_camera_transform_project_unit verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/vct_pkg.sv
rtl/core/vct_front.sv
rtl/core/vct_queue.sv
rtl/core/vct_div.sv
rtl/core/vct_back.sv
rtl/core/vertex_camera_transform_project_unit.sv
rtl/core/vct_checker.sv
verif/vct_scoreboard.sv
verif/vertex_camera_transform_project_unit_tb.sv
